>>> hw/rtl/lslf_pkg.sv
// Shared types, widths and codes for the least-squares line fit block.
package lslf_pkg;

  localparam int MAX_POINTS_DEF = 32;

  localparam int SX_W  = 21;
  localparam int SY_W  = 37;
  localparam int SXX_W = 36;
  localparam int SXY_W = 52;

  localparam int MA_W  = 22;
  localparam int MB_W  = 33;
  localparam int MP_W  = MA_W + MB_W;
  localparam int ACC_W = 60;
  localparam int HI_SH = 32;

  localparam int DVD_W = 58;
  localparam int DVS_W = 42;

  typedef enum logic [1:0] {
    FIT_OK   = 2'd0,
    FIT_FEW  = 2'd1,
    FIT_FLAT = 2'd2,
    FIT_OVER = 2'd3
  } fit_status_t;

  typedef struct packed {
    logic signed [15:0] raw_sample;
    logic signed [31:0] known_value;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    fit_status_t        fit_status;
  } fit_t;

  typedef struct packed {
    logic en;
    logic load;
    logic hi;
    logic sub;
  } mac_op_t;

endpackage

>>> hw/rtl/lslf_mac.sv
// Shared signed multiplier with a registered product and a shifting accumulator.
module lslf_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [lslf_pkg::MA_W-1:0]    a,
  input  logic signed [lslf_pkg::MB_W-1:0]    b,
  input  lslf_pkg::mac_op_t                   op,
  output logic signed [lslf_pkg::MP_W-1:0]    prod,
  output logic signed [lslf_pkg::ACC_W-1:0]   acc
);

  lslf_pkg::mac_op_t                 op_q;
  logic signed [lslf_pkg::ACC_W-1:0] prod_ext;
  logic signed [lslf_pkg::ACC_W-1:0] term;
  logic signed [lslf_pkg::ACC_W-1:0] base;

  always_comb begin
    prod_ext = {{(lslf_pkg::ACC_W - lslf_pkg::MP_W){prod[lslf_pkg::MP_W-1]}}, prod};
    term = op_q.hi ? {prod_ext[lslf_pkg::ACC_W-lslf_pkg::HI_SH-1:0],
                      {lslf_pkg::HI_SH{1'b0}}} : prod_ext;
    base = op_q.load ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    prod <= lslf_pkg::MP_W'(a) * lslf_pkg::MP_W'(b);
    if (rst) begin
      op_q <= '0;
    end else begin
      op_q <= op;
    end
    if (op_q.en) begin
      acc <= op_q.sub ? base - term : base + term;
    end
  end

endmodule

>>> hw/rtl/lslf_div.sv
// Unsigned restoring divider that retires one quotient bit per cycle.
module lslf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lslf_pkg::DVD_W-1:0]   dividend,
  input  logic [lslf_pkg::DVS_W-1:0]   divisor,
  output logic                         done,
  output logic [lslf_pkg::DVD_W-1:0]   quotient
);

  localparam int CW = $clog2(lslf_pkg::DVD_W);

  logic                        running;
  logic [CW-1:0]               cnt;
  logic [lslf_pkg::DVS_W-1:0]  rem;
  logic [lslf_pkg::DVS_W-1:0]  dvs;
  logic [lslf_pkg::DVS_W:0]    shifted;
  logic [lslf_pkg::DVS_W:0]    diff;
  logic                        ge;

  always_comb begin
    shifted = {rem, quotient[lslf_pkg::DVD_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= CW'(lslf_pkg::DVD_W - 1);
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
      end else if (running) begin
        rem      <= ge ? diff[lslf_pkg::DVS_W-1:0] : shifted[lslf_pkg::DVS_W-1:0];
        quotient <= {quotient[lslf_pkg::DVD_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/least_squares_line_fit.sv
// Top level: point accumulation, fit sequencer, shared multiplier and divider.
//
//  Channel   Ports                   Handshake
//  point     start, busy, point      taken when start is high and busy is low
//  fit       done, fit               shown for one cycle while done is high
//
// A point that is not last is taken in S_IDLE and then passes S_MXX, S_MXY and
// S_AXY on the shared multiplier for the squared and cross products; a point past
// the bound is not summed and sets the overflow flag. A successful fit makes two
// passes of the 58-step divider (slope, then intercept); a failed fit skips both.
// Reset is synchronous and clears all sums, the count and the overflow flag.
// The fit is sent as a one-cycle strobe on done; the block is idle in that cycle.
module least_squares_line_fit #(
  parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lslf_pkg::point_t point,
  output logic             done,
  output lslf_pkg::fit_t   fit
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MXX, S_MXY, S_AXY, S_CHK,
    S_D0, S_D1, S_D2, S_DW, S_DCHK,
    S_N0, S_N1, S_N2, S_N3, S_NW, S_NDIV, S_NWAIT,
    S_B0, S_B1, S_B2, S_BW, S_BDIV, S_BWAIT, S_OUT
  } state_t;

  state_t                              state;
  logic [CNT_W-1:0]                    point_count;
  logic                                count_overflowed;
  logic signed [lslf_pkg::SX_W-1:0]    sum_raw;
  logic signed [lslf_pkg::SY_W-1:0]    sum_known;
  logic [lslf_pkg::SXX_W-1:0]          sum_raw_squared;
  logic signed [lslf_pkg::SXY_W-1:0]   sum_raw_times_known;
  logic signed [15:0]                  x;
  logic signed [31:0]                  y;
  logic                                last;
  logic [lslf_pkg::DVS_W-1:0]          den;
  logic signed [31:0]                  m;
  logic signed [31:0]                  b;
  logic                                qneg;
  lslf_pkg::fit_status_t               status;

  logic signed [lslf_pkg::MA_W-1:0]    mac_a;
  logic signed [lslf_pkg::MB_W-1:0]    mac_b;
  lslf_pkg::mac_op_t                   mac_op;
  logic signed [lslf_pkg::MP_W-1:0]    prod;
  logic signed [lslf_pkg::ACC_W-1:0]   acc;
  logic [lslf_pkg::ACC_W-1:0]          acc_abs;
  logic                                div_start;
  logic [lslf_pkg::DVS_W-1:0]          div_divisor;
  logic                                div_done;
  logic [lslf_pkg::DVD_W-1:0]          quotient;
  logic signed [lslf_pkg::MA_W-1:0]    n_a;
  logic signed [lslf_pkg::MA_W-1:0]    sx_a;

  function automatic logic signed [31:0] sat_q(input logic neg,
                                              input logic [lslf_pkg::DVD_W-1:0] mag);
    logic signed [31:0] r;
    if (!neg) begin
      r = (mag > lslf_pkg::DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : mag[31:0];
    end else begin
      r = (mag > lslf_pkg::DVD_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -mag[31:0];
    end
    return r;
  endfunction

  assign busy = (state != S_IDLE);

  always_comb begin
    n_a       = {{(lslf_pkg::MA_W - CNT_W){1'b0}}, point_count};
    sx_a      = {{(lslf_pkg::MA_W - lslf_pkg::SX_W){sum_raw[lslf_pkg::SX_W-1]}}, sum_raw};
    acc_abs   = acc[lslf_pkg::ACC_W-1] ? -acc : acc;
    div_start = (state == S_NDIV) || (state == S_BDIV);
    div_divisor = (state == S_NDIV) ? den
                                    : {{(lslf_pkg::DVS_W - CNT_W){1'b0}}, point_count};
    mac_a  = '0;
    mac_b  = '0;
    mac_op = '0;
    unique case (state)
      S_MXX: begin
        mac_a = {{(lslf_pkg::MA_W - 16){x[15]}}, x};
        mac_b = {{(lslf_pkg::MB_W - 16){x[15]}}, x};
      end
      S_MXY: begin
        mac_a = {{(lslf_pkg::MA_W - 16){x[15]}}, x};
        mac_b = {y[31], y};
      end
      S_D0: begin
        mac_a  = n_a;
        mac_b  = {1'b0, sum_raw_squared[31:0]};
        mac_op = '{en: 1'b1, load: 1'b1, hi: 1'b0, sub: 1'b0};
      end
      S_D1: begin
        mac_a  = n_a;
        mac_b  = {{(lslf_pkg::MB_W - 4){1'b0}}, sum_raw_squared[35:32]};
        mac_op = '{en: 1'b1, load: 1'b0, hi: 1'b1, sub: 1'b0};
      end
      S_D2: begin
        mac_a  = sx_a;
        mac_b  = {{(lslf_pkg::MB_W - lslf_pkg::SX_W){sum_raw[lslf_pkg::SX_W-1]}}, sum_raw};
        mac_op = '{en: 1'b1, load: 1'b0, hi: 1'b0, sub: 1'b1};
      end
      S_N0: begin
        mac_a  = n_a;
        mac_b  = {1'b0, sum_raw_times_known[31:0]};
        mac_op = '{en: 1'b1, load: 1'b1, hi: 1'b0, sub: 1'b0};
      end
      S_N1: begin
        mac_a  = n_a;
        mac_b  = {{(lslf_pkg::MB_W - 20){sum_raw_times_known[51]}},
                  sum_raw_times_known[51:32]};
        mac_op = '{en: 1'b1, load: 1'b0, hi: 1'b1, sub: 1'b0};
      end
      S_N2: begin
        mac_a  = sx_a;
        mac_b  = {1'b0, sum_known[31:0]};
        mac_op = '{en: 1'b1, load: 1'b0, hi: 1'b0, sub: 1'b1};
      end
      S_N3: begin
        mac_a  = sx_a;
        mac_b  = {{(lslf_pkg::MB_W - 5){sum_known[36]}}, sum_known[36:32]};
        mac_op = '{en: 1'b1, load: 1'b0, hi: 1'b1, sub: 1'b1};
      end
      S_B0: begin
        mac_a  = lslf_pkg::MA_W'(1);
        mac_b  = {1'b0, sum_known[31:0]};
        mac_op = '{en: 1'b1, load: 1'b1, hi: 1'b0, sub: 1'b0};
      end
      S_B1: begin
        mac_a  = lslf_pkg::MA_W'(1);
        mac_b  = {{(lslf_pkg::MB_W - 5){sum_known[36]}}, sum_known[36:32]};
        mac_op = '{en: 1'b1, load: 1'b0, hi: 1'b1, sub: 1'b0};
      end
      S_B2: begin
        mac_a  = sx_a;
        mac_b  = {m[31], m};
        mac_op = '{en: 1'b1, load: 1'b0, hi: 1'b0, sub: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      point_count         <= '0;
      count_overflowed    <= 1'b0;
      sum_raw             <= '0;
      sum_known           <= '0;
      sum_raw_squared     <= '0;
      sum_raw_times_known <= '0;
      done                <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x    <= point.raw_sample;
            y    <= point.known_value;
            last <= point.last_point;
            if (point_count >= CNT_W'(MAX_POINTS)) begin
              count_overflowed <= 1'b1;
              state <= point.last_point ? S_CHK : S_IDLE;
            end else begin
              point_count <= point_count + 1'b1;
              sum_raw   <= sum_raw + {{(lslf_pkg::SX_W - 16){point.raw_sample[15]}},
                                      point.raw_sample};
              sum_known <= sum_known + {{(lslf_pkg::SY_W - 32){point.known_value[31]}},
                                        point.known_value};
              state <= S_MXX;
            end
          end
        end
        S_MXX: state <= S_MXY;
        S_MXY: begin
          sum_raw_squared <= sum_raw_squared + prod[lslf_pkg::SXX_W-1:0];
          state <= S_AXY;
        end
        S_AXY: begin
          sum_raw_times_known <= sum_raw_times_known + prod[lslf_pkg::SXY_W-1:0];
          state <= last ? S_CHK : S_IDLE;
        end
        S_CHK: begin
          m <= '0;
          b <= '0;
          if (count_overflowed) begin
            status <= lslf_pkg::FIT_OVER;
            state  <= S_OUT;
          end else if (point_count < CNT_W'(2)) begin
            status <= lslf_pkg::FIT_FEW;
            state  <= S_OUT;
          end else begin
            status <= lslf_pkg::FIT_OK;
            state  <= S_D0;
          end
        end
        S_D0: state <= S_D1;
        S_D1: state <= S_D2;
        S_D2: state <= S_DW;
        S_DW: state <= S_DCHK;
        S_DCHK: begin
          den <= acc[lslf_pkg::DVS_W-1:0];
          if (acc[lslf_pkg::ACC_W-1] || acc == '0) begin
            status <= lslf_pkg::FIT_FLAT;
            state  <= S_OUT;
          end else begin
            state <= S_N0;
          end
        end
        S_N0: state <= S_N1;
        S_N1: state <= S_N2;
        S_N2: state <= S_N3;
        S_N3: state <= S_NW;
        S_NW: state <= S_NDIV;
        S_NDIV: begin
          qneg  <= acc[lslf_pkg::ACC_W-1];
          state <= S_NWAIT;
        end
        S_NWAIT: begin
          if (div_done) begin
            m     <= sat_q(qneg, quotient);
            state <= S_B0;
          end
        end
        S_B0: state <= S_B1;
        S_B1: state <= S_B2;
        S_B2: state <= S_BW;
        S_BW: state <= S_BDIV;
        S_BDIV: begin
          qneg  <= acc[lslf_pkg::ACC_W-1];
          state <= S_BWAIT;
        end
        S_BWAIT: begin
          if (div_done) begin
            b     <= sat_q(qneg, quotient);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done                <= 1'b1;
          fit.slope           <= m;
          fit.intercept       <= b;
          fit.fit_status      <= status;
          point_count         <= '0;
          count_overflowed    <= 1'b0;
          sum_raw             <= '0;
          sum_known           <= '0;
          sum_raw_squared     <= '0;
          sum_raw_times_known <= '0;
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lslf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .a    (mac_a),
    .b    (mac_b),
    .op   (mac_op),
    .prod (prod),
    .acc  (acc)
  );

  lslf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_abs[lslf_pkg::DVD_W-1:0]),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Fit item shown while the sequencer is still busy.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
      (done && fit.fit_status != lslf_pkg::FIT_OK) |-> (fit.slope == '0 && fit.intercept == '0))
    else $error("Failed fit item carries a nonzero slope or intercept.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      point_count <= CNT_W'(MAX_POINTS))
    else $error("Point count ran past the store bound.");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
      done |-> (point_count == '0 && !count_overflowed && sum_raw == '0))
    else $error("Sums not cleared after a fit item.");

endmodule
